>>> rtl/core/assert_macros.svh
// Assertion macros used by the timer bank datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define STB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define STB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define STB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/stb_pkg.sv
// Types and constants of the software timer bank.
package stb_pkg;
	localparam int NumTimersDefault = 16;
	localparam int MaxOut = 16;
	localparam int CntW = 5;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0,
		OP_CONFIGURE = 3'd1,
		OP_START = 3'd2,
		OP_STOP = 3'd3,
		OP_RESET = 3'd4,
		OP_ELAPSED = 3'd5,
		OP_REMAINING = 3'd6,
		OP_TICK_COUNT = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic do_op;
		logic tick_start;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic slot_free;
		logic scan_last;
		logic emit_last;
	} status_t;
endpackage

>>> rtl/core/stb_if.sv
// Valid/ready channel interfaces for requests and results.
interface stb_req_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic [3:0] timer_index;
	logic [31:0] period_ms;
	logic auto_restart;
	modport source (output valid, operation, timer_index, period_ms, auto_restart, input ready);
	modport sink (input valid, operation, timer_index, period_ms, auto_restart, output ready);
endinterface

interface stb_rsp_if;
	logic valid;
	logic ready;
	logic expired_valid;
	logic [3:0] expired_index;
	logic [31:0] read_value;
	logic was_running;
	logic last;
	modport source (output valid, expired_valid, expired_index, read_value, was_running, last,
		input ready);
	modport sink (input valid, expired_valid, expired_index, read_value, was_running, last,
		output ready);
endinterface

>>> rtl/core/stb_ctrl.sv
// Sequencer of the timer bank: request intake, tick scan rounds, result issue.
module stb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input stb_pkg::status_t status,
	output stb_pkg::cmd_t cmd
);
	stb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (req_valid) state_d = stb_pkg::ST_OP;
			end
			stb_pkg::ST_OP: begin
				if (status.is_tick) state_d = stb_pkg::ST_SCAN;
				else if (status.slot_free) state_d = stb_pkg::ST_IDLE;
			end
			stb_pkg::ST_SCAN: begin
				if (status.scan_last) state_d = stb_pkg::ST_EMIT;
			end
			stb_pkg::ST_EMIT: begin
				if (status.slot_free) begin
					state_d = status.emit_last ? stb_pkg::ST_IDLE : stb_pkg::ST_SCAN;
				end
			end
			default: state_d = stb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.accept = req_valid;
			end
			stb_pkg::ST_OP: begin
				cmd.tick_start = status.is_tick;
				cmd.do_op = !status.is_tick && status.slot_free;
			end
			stb_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			stb_pkg::ST_EMIT: cmd.emit = status.slot_free;
			default: cmd = '0;
		endcase
	end
endmodule

>>> rtl/core/stb_datapath.sv
// Timer state, tick scan and result register of the timer bank.
`include "assert_macros.svh"
module stb_datapath #(
	parameter int NumTimers = stb_pkg::NumTimersDefault
) (
	input logic clk,
	input logic arst_n,
	input stb_pkg::cmd_t cmd,
	output stb_pkg::status_t status,
	input logic [2:0] operation,
	input logic [3:0] timer_index,
	input logic [31:0] period_ms,
	input logic auto_restart,
	output logic out_valid,
	input logic out_ready,
	output logic expired_valid,
	output logic [3:0] expired_index,
	output logic [31:0] read_value,
	output logic was_running,
	output logic last
);
	localparam int IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;

	logic [2:0] op_q;
	logic [3:0] idx_q;
	logic [31:0] per_q;
	logic auto_q;
	logic [31:0] tick_q;
	logic [31:0] period_q [NumTimers];
	logic [31:0] dl_q [NumTimers];
	logic [31:0] st_q [NumTimers];
	logic [NumTimers-1:0] run_q, perd_q, due_q;
	logic [IdxW-1:0] scan_q, best_q;
	logic [31:0] best_dl_q;
	logic found_q;
	logic [stb_pkg::CntW-1:0] cnt_q;

	logic ov_q, oe_q, ow_q, ol_q;
	logic [3:0] oi_q;
	logic [31:0] oval_q;

	logic [IdxW-1:0] tsel;
	logic in_range, was, slot_free;
	logic [31:0] tick_next, value;
	logic [NumTimers-1:0] other_due;

	assign tsel = IdxW'(idx_q);
	assign in_range = (32'(idx_q) < 32'(NumTimers));
	assign was = in_range && run_q[tsel];
	assign tick_next = tick_q + 32'd1;
	assign slot_free = !ov_q || out_ready;

	always_comb begin
		other_due = due_q;
		other_due[best_q] = 1'b0;
	end

	always_comb begin
		value = '0;
		case (stb_pkg::op_t'(op_q))
			stb_pkg::OP_STOP, stb_pkg::OP_ELAPSED: if (was) value = tick_q - st_q[tsel];
			stb_pkg::OP_REMAINING: if (was) value = dl_q[tsel] - tick_q;
			stb_pkg::OP_TICK_COUNT: value = tick_q;
			default: value = '0;
		endcase
	end

	assign status.is_tick = (stb_pkg::op_t'(op_q) == stb_pkg::OP_TICK);
	assign status.slot_free = slot_free;
	assign status.scan_last = (scan_q == IdxW'(NumTimers - 1));
	assign status.emit_last = !found_q || (other_due == '0) ||
		(cnt_q == stb_pkg::CntW'(stb_pkg::MaxOut - 1));

	// Latch the transferred request.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= operation;
			idx_q <= timer_index;
			per_q <= period_ms;
			auto_q <= auto_restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			run_q <= '0;
			perd_q <= '0;
			due_q <= '0;
			scan_q <= '0;
			best_q <= '0;
			best_dl_q <= '0;
			found_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			oe_q <= 1'b0;
			oi_q <= '0;
			oval_q <= '0;
			ow_q <= 1'b0;
			ol_q <= 1'b0;
			for (int i = 0; i < NumTimers; i++) begin
				period_q[i] <= '0;
				dl_q[i] <= '0;
				st_q[i] <= '0;
			end
		end else begin
			if (!(cmd.do_op || cmd.emit) && out_ready) ov_q <= 1'b0;
			if (cmd.do_op) begin
				ov_q <= 1'b1;
				oe_q <= 1'b0;
				oi_q <= '0;
				oval_q <= value;
				ow_q <= was && (stb_pkg::op_t'(op_q) != stb_pkg::OP_TICK_COUNT);
				ol_q <= 1'b1;
				if (in_range) begin
					case (stb_pkg::op_t'(op_q))
						stb_pkg::OP_CONFIGURE: begin
							period_q[tsel] <= per_q;
							perd_q[tsel] <= auto_q;
							run_q[tsel] <= 1'b0;
							st_q[tsel] <= '0;
							dl_q[tsel] <= '0;
						end
						stb_pkg::OP_START: begin
							st_q[tsel] <= tick_q;
							dl_q[tsel] <= tick_q + period_q[tsel];
							run_q[tsel] <= 1'b1;
						end
						stb_pkg::OP_STOP, stb_pkg::OP_RESET: begin
							run_q[tsel] <= 1'b0;
							st_q[tsel] <= '0;
							dl_q[tsel] <= '0;
						end
						default: ;
					endcase
				end
			end
			if (cmd.tick_start) begin
				tick_q <= tick_next;
				for (int i = 0; i < NumTimers; i++) begin
					due_q[i] <= run_q[i] && (dl_q[i] <= tick_next);
				end
				cnt_q <= '0;
				scan_q <= '0;
				found_q <= 1'b0;
			end
			// Advance the search for the earliest due deadline.
			if (cmd.scan_step) begin
				if (due_q[scan_q] && (!found_q || dl_q[scan_q] < best_dl_q)) begin
					found_q <= 1'b1;
					best_q <= scan_q;
					best_dl_q <= dl_q[scan_q];
				end
				if (!status.scan_last) scan_q <= scan_q + IdxW'(1);
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
				oe_q <= found_q;
				oi_q <= found_q ? 4'(best_q) : 4'd0;
				oval_q <= '0;
				ow_q <= found_q;
				ol_q <= status.emit_last;
				scan_q <= '0;
				found_q <= 1'b0;
				if (found_q) begin
					due_q[best_q] <= 1'b0;
					cnt_q <= cnt_q + stb_pkg::CntW'(1);
					if (perd_q[best_q]) begin
						st_q[best_q] <= tick_q;
						dl_q[best_q] <= tick_q + period_q[best_q];
					end else begin
						run_q[best_q] <= 1'b0;
					end
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign expired_valid = oe_q;
	assign expired_index = oi_q;
	assign read_value = oval_q;
	assign was_running = ow_q;
	assign last = ol_q;

	`STB_ASSERT(a_cnt_bound, cnt_q <= stb_pkg::CntW'(stb_pkg::MaxOut), "too many expiries")
	`STB_ASSERT_IMP(a_no_overwrite, cmd.emit || cmd.do_op, slot_free, "pending result lost")
	`STB_ASSERT_IMP(a_best_due, found_q, due_q[best_q], "selected timer not due")
	`STB_ASSERT_NXT(a_tick_clear, cmd.tick_start, cnt_q == '0 && !found_q, "scan not cleared")
endmodule

>>> rtl/core/software_timer_bank.sv
// Top level of the software timer bank.
// Usage:
//   req carries one operation per transfer (tick, configure, start, stop,
//   reset, elapsed, remaining, tick count) with timer index, period and mode.
//   rsp carries result items; the final result of an operation has last set.
// Sequence:
//   - non-tick operations: transfer, execute step, result registered; the
//     execute step waits while an earlier result still waits for rsp.
//   - tick: advance the count and flag due timers, then for each expiry a
//     scan through the whole deadline table plus an issue step, expiries
//     capped at sixteen; with no expiry, a single scan and issue step.
//     One shared compare steps through the deadline table a timer at a time.
//   - req is taken only between operations; one request at a time.
// Reset: count zero, all timers idle and one-shot, periods and deadlines zero.
// Stall: a waiting result holds in the output register; the sequencer holds
//   before issuing the next result until rsp takes the waiting one, and a new
//   request is still taken while the last result waits.
module software_timer_bank #(
	parameter int NUM_TIMERS = stb_pkg::NumTimersDefault
) (
	input logic clk,
	input logic arst_n,
	stb_req_if.sink req,
	stb_rsp_if.source rsp
);
	stb_pkg::cmd_t cmd;
	stb_pkg::status_t status;

	// Sequencer: owns request intake and the tick scan rounds.
	stb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.status(status),
		.cmd(cmd)
	);

	// Datapath: timer table, tick count and the result register.
	stb_datapath #(.NumTimers(NUM_TIMERS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.operation(req.operation),
		.timer_index(req.timer_index),
		.period_ms(req.period_ms),
		.auto_restart(req.auto_restart),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.expired_valid(rsp.expired_valid),
		.expired_index(rsp.expired_index),
		.read_value(rsp.read_value),
		.was_running(rsp.was_running),
		.last(rsp.last)
	);
endmodule
